### rtl/binary_erode_dilate_2d_core_assert.svh
// Assertion helpers for the erode/dilate core. Each macro expects clk and arst_n in scope.
`ifndef BINARY_ERODE_DILATE_2D_CORE_ASSERT_SVH
`define BINARY_ERODE_DILATE_2D_CORE_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define BEDC_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define BEDC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/bedc_pkg.sv
`default_nettype none
package bedc_pkg;

	localparam int CFG_DATA_W = 25;
	localparam int CFG_IDX_W  = 2;
	localparam int DIM_W      = 11;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE_ERODE   = 2'd0,
		REG_ELEMENT_MASK = 2'd1,
		REG_IMAGE_WIDTH  = 2'd2,
		REG_IMAGE_HEIGHT = 2'd3
	} reg_idx_t;

	localparam logic                  RST_MODE_ERODE = 1'b1;
	localparam logic [CFG_DATA_W-1:0] RST_ELEMENT    = 25'd462;
	localparam logic [DIM_W-1:0]      RST_WIDTH      = 11'd640;
	localparam logic [DIM_W-1:0]      RST_HEIGHT     = 11'd480;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_AW    = 2;
	localparam int OUTQ_CW    = 3;

	typedef struct packed {
		logic en;
		logic load;
	} cell_ctl_t;

	typedef struct packed {
		logic pixel_out;
		logic frame_end;
	} out_item_t;

endpackage
`default_nettype wire

### rtl/bedc_in_if.sv
`default_nettype none
interface bedc_in_if;
	logic valid;
	logic ready;
	logic kind;
	logic pixel_in;

	modport source (output valid, output kind, output pixel_in, input ready);
	modport sink (input valid, input kind, input pixel_in, output ready);
endinterface
`default_nettype wire

### rtl/bedc_out_if.sv
`default_nettype none
interface bedc_out_if;
	logic valid;
	logic ready;
	logic pixel_out;
	logic frame_end;

	modport source (output valid, output pixel_out, output frame_end, input ready);
	modport sink (input valid, input pixel_out, input frame_end, output ready);
endinterface
`default_nettype wire

### rtl/bedc_cfg_if.sv
`default_nettype none
interface bedc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [bedc_pkg::CFG_IDX_W-1:0]  index;
	logic [bedc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### rtl/binary_erode_dilate_2d_core.sv
`default_nettype none
// Binary erosion and dilation of a raster-order pixel stream under a square
// structuring element of ELEMENT_SIZE x ELEMENT_SIZE set through the
// configuration port. The core takes one item per clock while input ready is high
// and gives at most one result per accepted item, in raster order; the item that
// completes a neighborhood sends its result through stages s1 and s2 into the
// result queue; that item brings in the pixel R rows below and R columns to the
// right of the result (clamped to the frame), R being ELEMENT_SIZE/2. The results
// of the last R rows of a frame therefore wait for flush items or for pixels of
// the next frame, one result per item. Input ready drops only when four results
// are held or still in the pipeline, so a consumer that takes a result each cycle
// sees a full rate of one item per clock. The line store keeps a ring of rows per
// column in a single memory read once per result; it is not cleared after reset,
// and needs no clearing pass since a result only reads pixels of its own frame.
// The user writes configuration while the core is idle; it is not enforced.
`include "binary_erode_dilate_2d_core_assert.svh"
module binary_erode_dilate_2d_core #(
	parameter int MAX_WIDTH    = 1024,
	parameter int MAX_HEIGHT   = 1024,
	parameter int ELEMENT_SIZE = 5
) (
	input  wire        clk,
	input  wire        arst_n,
	bedc_in_if.sink    in_ch,
	bedc_out_if.source out_ch,
	bedc_cfg_if.sink   cfg
);

	localparam int R         = ELEMENT_SIZE / 2;
	localparam int NE        = ELEMENT_SIZE * ELEMENT_SIZE;
	localparam int CENTER    = NE / 2;
	localparam int DW        = $clog2(MAX_WIDTH + 1);
	localparam int CA        = $clog2(MAX_WIDTH);
	localparam int HW        = $clog2(MAX_HEIGHT + 1);
	localparam int RB        = $clog2(4 * R + 8);
	localparam int RING_ROWS = 1 << RB;
	localparam int SQ        = RB + 2;

	// Configuration registers; the port always takes a write.
	logic          mode_q;
	logic [NE-1:0] mask_q;
	logic [bedc_pkg::DIM_W-1:0] width_q;
	logic [bedc_pkg::DIM_W-1:0] height_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= bedc_pkg::RST_MODE_ERODE;
			mask_q   <= NE'(bedc_pkg::RST_ELEMENT);
			width_q  <= bedc_pkg::RST_WIDTH;
			height_q <= bedc_pkg::RST_HEIGHT;
		end else if (cfg.valid) begin
			unique case (bedc_pkg::reg_idx_t'(cfg.index))
				bedc_pkg::REG_MODE_ERODE:   mode_q   <= cfg.data[0];
				bedc_pkg::REG_ELEMENT_MASK: mask_q   <= NE'(cfg.data);
				bedc_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg.data[bedc_pkg::DIM_W-1:0];
				bedc_pkg::REG_IMAGE_HEIGHT: height_q <= cfg.data[bedc_pkg::DIM_W-1:0];
			endcase
		end
	end

	// Frame geometry in use, saturated to the supported range.
	logic [DW-1:0] w;
	logic [HW-1:0] h;

	always_comb begin
		if (width_q == '0) begin
			w = DW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w = DW'(MAX_WIDTH);
		end else begin
			w = DW'(width_q);
		end
		if (height_q == '0) begin
			h = HW'(1);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			h = HW'(MAX_HEIGHT);
		end else begin
			h = HW'(height_q);
		end
	end

	// Input side position and row sequence number.
	logic          in_acc;
	logic          is_pix;
	logic [DW-1:0] in_col_q, in_col_n, wcol;
	logic [HW-1:0] in_row_q, in_row_n;
	logic [SQ-1:0] in_seq_q, in_seq_n;

	// Result side position and row sequence number.
	logic [DW-1:0] out_col_q, out_col_n;
	logic [HW-1:0] out_row_q, out_row_n;
	logic [SQ-1:0] out_seq_q, out_seq_n;

	logic [DW-1:0] c, need_col;
	logic [HW-1:0] r, dnr;
	logic [SQ-1:0] need_seq, seq_gap;
	logic          job_ready;
	logic [RB-1:0] rowidx_d [ELEMENT_SIZE];

	// Pipeline: s1 holds the job while the line store is read, s2 slides the window.
	logic          v_s1, v_s2;
	logic          first_s1, first_s2;
	logic          fend_s1, fend_s2;
	logic [CA-1:0] raddr_s1;
	logic [RB-1:0] rowidx_s1 [ELEMENT_SIZE];
	logic [RB-1:0] rowidx_s2 [ELEMENT_SIZE];

	logic [bedc_pkg::OUTQ_CW-1:0] oq_cnt;

	assign in_acc      = in_ch.valid && in_ch.ready;
	assign is_pix      = (in_ch.kind == bedc_pkg::KIND_PIXEL);
	assign in_ch.ready = (32'(oq_cnt) + 32'(v_s1) + 32'(v_s2)) < bedc_pkg::OUTQ_DEPTH;
	assign wcol        = (in_col_q < w) ? in_col_q : w - 1'b1;

	always_comb begin
		in_col_n = in_col_q;
		in_row_n = in_row_q;
		in_seq_n = in_seq_q;
		if (is_pix) begin
			if (32'(in_col_q) + 1 >= 32'(w)) begin
				in_col_n = '0;
				in_seq_n = in_seq_q + 1'b1;
				in_row_n = (32'(in_row_q) + 1 >= 32'(h)) ? '0 : in_row_q + 1'b1;
			end else begin
				in_col_n = in_col_q + 1'b1;
			end
		end
	end

	// A result is ready once the input has passed the lowest, rightmost pixel of
	// its neighborhood, both clamped to the frame.
	always_comb begin
		r        = (out_row_q < h) ? out_row_q : h - 1'b1;
		c        = (out_col_q < w) ? out_col_q : w - 1'b1;
		dnr      = h - 1'b1 - r;
		need_seq = out_seq_q + ((32'(dnr) < R) ? SQ'(dnr) : SQ'(R));
		need_col = (32'(c) + R < 32'(w)) ? DW'(32'(c) + R) : w - 1'b1;
		seq_gap  = in_seq_n - need_seq;
		job_ready = ((seq_gap != '0) && !seq_gap[SQ-1]) ||
			((seq_gap == '0) && (in_col_n > need_col));
		for (int j = 0; j < ELEMENT_SIZE; j++) begin
			if (j < R) begin
				rowidx_d[j] = (32'(r) < R - j) ? RB'(out_seq_q - SQ'(r)) :
					RB'(out_seq_q - SQ'(R - j));
			end else begin
				rowidx_d[j] = (32'(dnr) < j - R) ? RB'(out_seq_q + SQ'(dnr)) :
					RB'(out_seq_q + SQ'(j - R));
			end
		end
	end

	always_comb begin
		out_col_n = out_col_q;
		out_row_n = out_row_q;
		out_seq_n = out_seq_q;
		if (32'(out_col_q) + 1 >= 32'(w)) begin
			out_col_n = '0;
			out_seq_n = out_seq_q + 1'b1;
			out_row_n = (32'(out_row_q) + 1 >= 32'(h)) ? '0 : out_row_q + 1'b1;
		end else begin
			out_col_n = out_col_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			in_seq_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			out_seq_q <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
		end else begin
			v_s1 <= in_acc && job_ready;
			v_s2 <= v_s1;
			if (in_acc) begin
				in_col_q <= in_col_n;
				in_row_q <= in_row_n;
				in_seq_q <= in_seq_n;
				if (job_ready) begin
					out_col_q <= out_col_n;
					out_row_q <= out_row_n;
					out_seq_q <= out_seq_n;
				end
			end
		end
	end

	// Job payload needs no reset; the valid bits above qualify it.
	always_ff @(posedge clk) begin
		first_s1  <= (c == '0);
		fend_s1   <= (r == h - 1'b1) && (c == w - 1'b1);
		raddr_s1  <= need_col[CA-1:0];
		rowidx_s1 <= rowidx_d;
		first_s2  <= first_s1;
		fend_s2   <= fend_s1;
		rowidx_s2 <= rowidx_s1;
	end

	logic [RING_ROWS-1:0] rdata_s2;
	logic [RING_ROWS-1:0] shadow_q [R];

	bedc_linebuf #(
		.DEPTH   (MAX_WIDTH),
		.RING    (RING_ROWS),
		.SHADOWS (R)
	) u_linebuf (
		.clk      (clk),
		.we       (in_acc && is_pix),
		.waddr    (wcol[CA-1:0]),
		.wrow     (in_seq_q[RB-1:0]),
		.wbit     (in_ch.pixel_in),
		.raddr    (raddr_s1),
		.rdata_s2 (rdata_s2),
		.shadow_q (shadow_q)
	);

	// Pick the job's rows out of the column words.
	logic [ELEMENT_SIZE-1:0] new_slice;
	logic [ELEMENT_SIZE-1:0] sh_slice [R];

	always_comb begin
		for (int a = 0; a < ELEMENT_SIZE; a++) begin
			new_slice[a] = rdata_s2[rowidx_s2[a]];
			for (int j = 0; j < R; j++) begin
				sh_slice[j][a] = shadow_q[j][rowidx_s2[a]];
			end
		end
	end

	// At a row start the window covers columns -R..R clamped to the frame; the
	// left part comes from the mirrored columns and the last column from memory.
	logic [ELEMENT_SIZE-1:0] load_bits [ELEMENT_SIZE];

	always_comb begin
		for (int k = 0; k < ELEMENT_SIZE; k++) begin
			load_bits[k] = new_slice;
			if (k < ELEMENT_SIZE - 1) begin
				load_bits[k] = sh_slice[0];
				for (int j = 0; j < R; j++) begin
					if ((j <= ((k < R) ? 0 : k - R)) && (32'(w) > j)) begin
						load_bits[k] = sh_slice[j];
					end
				end
			end
		end
	end

	bedc_pkg::cell_ctl_t     cell_ctl;
	logic [ELEMENT_SIZE-1:0] col_d [ELEMENT_SIZE];
	logic [ELEMENT_SIZE-1:0] col_q [ELEMENT_SIZE];

	assign cell_ctl.en   = v_s2;
	assign cell_ctl.load = first_s2;

	for (genvar k = 0; k < ELEMENT_SIZE; k++) begin : g_cell
		logic [ELEMENT_SIZE-1:0] nb;
		if (k < ELEMENT_SIZE - 1) begin : g_mid
			assign nb = col_q[k+1];
		end else begin : g_end
			assign nb = new_slice;
		end
		bedc_cell #(
			.ROWS (ELEMENT_SIZE)
		) u_cell (
			.clk       (clk),
			.ctl       (cell_ctl),
			.load_bits (load_bits[k]),
			.next_bits (nb),
			.col_d     (col_d[k]),
			.col_q     (col_q[k])
		);
	end

	// Combine the window under the element. Dilation reads the reflected offset.
	logic [NE-1:0] use_v, bits_v;
	logic          acc0, result;

	always_comb begin
		int ady;
		int adx;
		for (int a = 0; a < ELEMENT_SIZE; a++) begin
			for (int b = 0; b < ELEMENT_SIZE; b++) begin
				ady = (a < R) ? R - a : a - R;
				adx = (b < R) ? R - b : b - R;
				bits_v[a*ELEMENT_SIZE+b] = mode_q ? col_d[b][a] :
					col_d[ELEMENT_SIZE-1-b][ELEMENT_SIZE-1-a];
				use_v[a*ELEMENT_SIZE+b] = mask_q[a*ELEMENT_SIZE+b] &&
					((a*ELEMENT_SIZE + b) != CENTER) &&
					(32'(h) > ady) && (32'(w) > adx);
			end
		end
		acc0   = mask_q[CENTER] ? col_d[R][R] : mode_q;
		result = mode_q ? (acc0 & ~|(use_v & ~bits_v)) : (acc0 | |(use_v & bits_v));
	end

	bedc_pkg::out_item_t push_item;

	assign push_item.pixel_out = result;
	assign push_item.frame_end = fend_s2;

	bedc_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s2),
		.push_item (push_item),
		.cnt_q     (oq_cnt),
		.out_ch    (out_ch)
	);

	`BEDC_ASSERT_ALWAYS(a_queue_room, (32'(oq_cnt) + 32'(v_s1) + 32'(v_s2)) <= bedc_pkg::OUTQ_DEPTH, "result queue overrun")
	`BEDC_ASSERT_NEXT(a_job_moves, v_s1, v_s2, "job lost between read and window stage")
	`BEDC_ASSERT_NEXT(a_flush_holds_col, in_acc && (in_ch.kind == bedc_pkg::KIND_FLUSH), in_col_q == $past(in_col_q), "flush item moved the input column")

endmodule
`default_nettype wire

### rtl/bedc_cell.sv
`default_nettype none
// One column of the neighborhood window. It either takes a fresh column at a
// row start or the column of its right-hand neighbor when the window slides.
module bedc_cell #(
	parameter int ROWS = 5
) (
	input  wire                  clk,
	input  bedc_pkg::cell_ctl_t  ctl,
	input  wire  [ROWS-1:0]      load_bits,
	input  wire  [ROWS-1:0]      next_bits,
	output logic [ROWS-1:0]      col_d,
	output logic [ROWS-1:0]      col_q
);

	always_comb begin
		if (!ctl.en) begin
			col_d = col_q;
		end else if (ctl.load) begin
			col_d = load_bits;
		end else begin
			col_d = next_bits;
		end
	end

	always_ff @(posedge clk) begin
		col_q <= col_d;
	end

endmodule
`default_nettype wire

### rtl/bedc_linebuf.sv
`default_nettype none
// Line store: one word per column holding a ring of rows, written one bit at a
// time, with a registered read port. The first few columns are mirrored in
// registers so a row start can fill the left side of the window at once.
module bedc_linebuf #(
	parameter int DEPTH   = 1024,
	parameter int RING    = 16,
	parameter int SHADOWS = 2
) (
	input  wire                        clk,
	input  wire                        we,
	input  wire  [$clog2(DEPTH)-1:0]   waddr,
	input  wire  [$clog2(RING)-1:0]    wrow,
	input  wire                        wbit,
	input  wire  [$clog2(DEPTH)-1:0]   raddr,
	output logic [RING-1:0]            rdata_s2,
	output logic [RING-1:0]            shadow_q [SHADOWS]
);

	logic [RING-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr][wrow] <= wbit;
		end
		rdata_s2 <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < SHADOWS; j++) begin
			if (we && (32'(waddr) == j)) begin
				shadow_q[j][wrow] <= wbit;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/bedc_outq.sv
`default_nettype none
// Small result queue that decouples the window pipeline from the consumer.
module bedc_outq (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                push,
	input  bedc_pkg::out_item_t                push_item,
	output logic [bedc_pkg::OUTQ_CW-1:0]       cnt_q,
	bedc_out_if.source                         out_ch
);

	bedc_pkg::out_item_t               buf_q [bedc_pkg::OUTQ_DEPTH];
	logic [bedc_pkg::OUTQ_AW-1:0]      wr_q;
	logic [bedc_pkg::OUTQ_AW-1:0]      rd_q;
	logic                              pop;

	assign out_ch.valid     = (cnt_q != '0);
	assign out_ch.pixel_out = buf_q[rd_q].pixel_out;
	assign out_ch.frame_end = buf_q[rd_q].frame_end;
	assign pop              = out_ch.valid && out_ch.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + bedc_pkg::OUTQ_CW'(push) - bedc_pkg::OUTQ_CW'(pop);
		end
	end

endmodule
`default_nettype wire
